// ----- sv/gconv_pkg.sv -----
// Shared types and constants for the grouped convolution engine.
// No dependencies; the engine and the testbench import this package.
`default_nettype none

package gconv_pkg;

  typedef enum logic [2:0] {
    KIND_WEIGHT = 3'd0,
    KIND_BIAS   = 3'd1,
    KIND_PIXEL  = 3'd2,
    KIND_START  = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_SIZE  = 2'd1,
    STATUS_BAD_COUNT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_IN_HEIGHT    = 3'd0,
    REG_IN_WIDTH     = 3'd1,
    REG_IN_CHANNELS  = 3'd2,
    REG_KERNEL_COUNT = 3'd3,
    REG_STRIDE_ROWS  = 3'd4,
    REG_STRIDE_COLS  = 3'd5,
    REG_PAD_ROWS     = 3'd6,
    REG_PAD_COLS     = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_WALK,
    ST_DRAIN
  } state_t;

  localparam int VALUE_W  = 16;
  localparam int RESULT_W = 40;
  localparam int ACC_W    = 48;
  localparam int DIM_W    = 8;
  localparam int CNT_W    = 5;
  localparam int TAP_W    = 3;
  localparam int POS_W    = 10;

  localparam logic signed [ACC_W-1:0] SAT_HI = 48'sh007F_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_LO = 48'shFF80_0000_0000;

endpackage

`default_nettype wire

// ----- sv/grouped_conv2d_engine_unit.sv -----
// Grouped 2D convolution engine. Weight, bias and pixel loads are taken one
// item per cycle while the engine is idle and no result is stalled; a read item
// passes through a read state for the output memory read. A start item first
// finds the output size with a subtract-and-count divider, then walks every
// output of every kernel one kernel tap per cycle through the single pixel and
// weight memory read ports, and then drains the adder chain. Each tap product
// enters a chain of KERNEL_COLS adder cells, so one kernel row leaves the chain
// as one partial sum. Results are signed Q24.16 saturated to 40 bits. Depends on
// gconv_pkg, gconv_ram and gconv_cell.
`default_nettype none

module grouped_conv2d_engine_unit
  import gconv_pkg::*;
#(
  parameter int KERNEL_ROWS  = 3,
  parameter int KERNEL_COLS  = 3,
  parameter int GROUP_COUNT  = 1,
  parameter int MAX_DIM      = 64,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_KERNELS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [6:0]          cfg_data,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic [2:0]          kind,
  input  wire logic [3:0]          kernel_sel,
  input  wire logic [3:0]          chan_sel,
  input  wire logic [5:0]          row_sel,
  input  wire logic [5:0]          col_sel,
  input  wire logic signed [15:0]  value,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output logic signed [39:0]       result_value,
  output logic [1:0]               status,
  output logic                     is_read
);

  localparam int PLANE     = MAX_DIM * MAX_DIM;
  localparam int WIN       = KERNEL_ROWS * KERNEL_COLS;
  localparam int PIX_DEPTH = MAX_CHANNELS * PLANE;
  localparam int WGT_DEPTH = MAX_KERNELS * MAX_CHANNELS * WIN;
  localparam int OUT_DEPTH = MAX_KERNELS * PLANE;
  localparam int PIX_AW    = PIX_DEPTH > 1 ? $clog2(PIX_DEPTH) : 1;
  localparam int WGT_AW    = WGT_DEPTH > 1 ? $clog2(WGT_DEPTH) : 1;
  localparam int OUT_AW    = OUT_DEPTH > 1 ? $clog2(OUT_DEPTH) : 1;
  localparam int KIDX_W    = MAX_KERNELS > 1 ? $clog2(MAX_KERNELS) : 1;
  localparam int PSUM_W    = 2 * VALUE_W + $clog2(KERNEL_COLS) + 1;
  localparam int TAG_W     = 3 + KIDX_W + OUT_AW;
  localparam int DRAIN_N   = KERNEL_COLS + 4;
  localparam int DRAIN_W   = $clog2(DRAIN_N + 1);

  // Configuration registers.
  logic [6:0] in_height, in_width;
  logic [4:0] in_channels, kernel_count;
  logic [3:0] stride_rows, stride_cols;
  logic [2:0] pad_rows, pad_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height    <= 7'd8;
      in_width     <= 7'd8;
      in_channels  <= 5'd1;
      kernel_count <= 5'd1;
      stride_rows  <= 4'd1;
      stride_cols  <= 4'd1;
      pad_rows     <= 3'd0;
      pad_cols     <= 3'd0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_IN_HEIGHT:    in_height    <= cfg_data;
        REG_IN_WIDTH:     in_width     <= cfg_data;
        REG_IN_CHANNELS:  in_channels  <= cfg_data[4:0];
        REG_KERNEL_COUNT: kernel_count <= cfg_data[4:0];
        REG_STRIDE_ROWS:  stride_rows  <= cfg_data[3:0];
        REG_STRIDE_COLS:  stride_cols  <= cfg_data[3:0];
        REG_PAD_ROWS:     pad_rows     <= cfg_data[2:0];
        REG_PAD_COLS:     pad_cols     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic   req_acc, rsp_acc;

  assign req_acc = req_valid && !req_stall;
  assign rsp_acc = rsp_valid && !rsp_stall;

  // Start checks on the register file.
  logic [DIM_W-1:0] ph, pw;
  logic             size_bad, count_bad, ic_div_ok, kc_div_ok;
  logic [CNT_W-1:0] cpg, kpg;

  assign ph = DIM_W'(in_height) + DIM_W'({pad_rows, 1'b0});
  assign pw = DIM_W'(in_width) + DIM_W'({pad_cols, 1'b0});
  assign size_bad = (stride_rows == '0) || (stride_cols == '0) ||
                    (in_height == '0) || (in_width == '0) ||
                    (32'(in_height) > MAX_DIM) || (32'(in_width) > MAX_DIM) ||
                    (32'(ph) < KERNEL_ROWS) || (32'(pw) < KERNEL_COLS);

  // Quotients by the group count, found by matching the candidates in parallel.
  always_comb begin
    cpg       = '0;
    kpg       = '0;
    ic_div_ok = 1'b0;
    kc_div_ok = 1'b0;
    for (int j = 0; j < 32; j++) begin
      if (j * GROUP_COUNT == int'(in_channels)) begin
        cpg       = CNT_W'(j);
        ic_div_ok = 1'b1;
      end
      if (j * GROUP_COUNT == int'(kernel_count)) begin
        kpg       = CNT_W'(j);
        kc_div_ok = 1'b1;
      end
    end
  end

  assign count_bad = (in_channels == '0) || (32'(in_channels) > MAX_CHANNELS) ||
                     (kernel_count == '0) || (32'(kernel_count) > MAX_KERNELS) ||
                     !ic_div_ok || !kc_div_ok;

  // Output size divider and its outcome.
  logic [DIM_W-1:0] rem_r, rem_c, quo_r, quo_c;
  logic [DIM_W-1:0] out_rows, out_cols;
  logic             div_done, oh_bad;

  assign div_done = (rem_r < DIM_W'(stride_rows)) && (rem_c < DIM_W'(stride_cols));
  assign oh_bad   = (32'(quo_r) + 1 > MAX_DIM) || (32'(quo_c) + 1 > MAX_DIM);

  // Walker counters.
  logic [CNT_W-1:0]        k, kg, base_ch, c;
  logic [DIM_W-1:0]        oy, ox;
  logic [TAP_W-1:0]        r, q;
  logic signed [POS_W-1:0] ybase, xbase, y, x;
  logic                    tap_ok, last_tap;
  logic                    q_end, r_end, c_end, ox_end, oy_end, k_end;
  logic [CNT_W:0]          ch;
  logic [DRAIN_W-1:0]      drain_cnt;

  assign y        = ybase + POS_W'(r);
  assign x        = xbase + POS_W'(q);
  assign tap_ok   = !y[POS_W-1] && (y < $signed(POS_W'(in_height))) &&
                    !x[POS_W-1] && (x < $signed(POS_W'(in_width)));
  assign ch       = (CNT_W+1)'(base_ch) + (CNT_W+1)'(c);
  assign q_end    = 32'(q) == KERNEL_COLS - 1;
  assign r_end    = 32'(r) == KERNEL_ROWS - 1;
  assign c_end    = c == cpg - 1'b1;
  assign ox_end   = ox == out_cols - 1'b1;
  assign oy_end   = oy == out_rows - 1'b1;
  assign k_end    = k == kernel_count - 1'b1;
  assign last_tap = q_end && r_end && c_end && ox_end && oy_end && k_end;

  // Memory ports.
  logic                    pix_we, wgt_we, out_we;
  logic [PIX_AW-1:0]       pix_waddr, pix_raddr;
  logic [WGT_AW-1:0]       wgt_waddr, wgt_raddr;
  logic [OUT_AW-1:0]       out_waddr, out_raddr, tap_oaddr;
  logic signed [15:0]      pix_rdata, wgt_rdata;
  logic [RESULT_W-1:0]     out_wdata, out_rdata;
  kind_t                   kind_in;

  assign kind_in   = kind_t'(kind);
  assign pix_we    = req_acc && kind_in == KIND_PIXEL && 32'(chan_sel) < MAX_CHANNELS &&
                     32'(row_sel) < MAX_DIM && 32'(col_sel) < MAX_DIM;
  assign wgt_we    = req_acc && kind_in == KIND_WEIGHT && 32'(kernel_sel) < MAX_KERNELS &&
                     32'(chan_sel) < MAX_CHANNELS && 32'(row_sel) < KERNEL_ROWS &&
                     32'(col_sel) < KERNEL_COLS;
  assign pix_waddr = PIX_AW'(32'(chan_sel) * PLANE + 32'(row_sel) * MAX_DIM + 32'(col_sel));
  assign wgt_waddr = WGT_AW'((32'(kernel_sel) * MAX_CHANNELS + 32'(chan_sel)) * WIN +
                             32'(row_sel) * KERNEL_COLS + 32'(col_sel));
  assign pix_raddr = PIX_AW'(32'(ch) * PLANE + 32'(y[POS_W-2:0]) * MAX_DIM +
                             32'(x[POS_W-2:0]));
  assign wgt_raddr = WGT_AW'((32'(k) * MAX_CHANNELS + 32'(c)) * WIN +
                             32'(r) * KERNEL_COLS + 32'(q));
  assign tap_oaddr = OUT_AW'(32'(k) * PLANE + 32'(oy) * MAX_DIM + 32'(ox));
  assign out_raddr = OUT_AW'(32'(kernel_sel) * PLANE + 32'(row_sel) * MAX_DIM +
                             32'(col_sel));

  gconv_ram #(.WIDTH(VALUE_W), .DEPTH(PIX_DEPTH)) u_pix_ram (
    .clk(clk), .we(pix_we), .waddr(pix_waddr), .wdata(value),
    .raddr(pix_raddr), .rdata(pix_rdata)
  );

  gconv_ram #(.WIDTH(VALUE_W), .DEPTH(WGT_DEPTH)) u_wgt_ram (
    .clk(clk), .we(wgt_we), .waddr(wgt_waddr), .wdata(value),
    .raddr(wgt_raddr), .rdata(wgt_rdata)
  );

  gconv_ram #(.WIDTH(RESULT_W), .DEPTH(OUT_DEPTH)) u_out_ram (
    .clk(clk), .we(out_we), .waddr(out_waddr), .wdata(out_wdata),
    .raddr(out_raddr), .rdata(out_rdata)
  );

  // Bias store, cleared at reset.
  logic signed [15:0] bias_mem [MAX_KERNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_KERNELS; i++) begin
        bias_mem[i] <= '0;
      end
    end else if (req_acc && kind_in == KIND_BIAS && 32'(kernel_sel) < MAX_KERNELS) begin
      bias_mem[KIDX_W'(kernel_sel)] <= value;
    end
  end

  // Tap pipeline: tag is {kernel, output address, last row, first row, row start}.
  logic [TAG_W-1:0]         issue_tag, d1_tag, prod_tag;
  logic                     d1_ok;
  logic signed [PSUM_W-1:0] prod;
  logic signed [PSUM_W-1:0] psum_chain [KERNEL_COLS+1];
  logic [TAG_W-1:0]         tag_chain  [KERNEL_COLS+1];

  assign issue_tag = {KIDX_W'(k), tap_oaddr, r_end && c_end,
                      (r == '0) && (c == '0), (state == ST_WALK) && (q == '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_tag   <= '0;
      prod_tag <= '0;
    end else begin
      d1_tag   <= issue_tag;
      prod_tag <= d1_tag;
    end
  end

  always_ff @(posedge clk) begin
    d1_ok <= tap_ok;
    prod  <= d1_ok ? PSUM_W'(pix_rdata * wgt_rdata) : '0;
  end

  assign psum_chain[0] = '0;
  assign tag_chain[0]  = prod_tag;

  for (genvar g = 0; g < KERNEL_COLS; g++) begin : g_cell
    gconv_cell #(.PSUM_W(PSUM_W), .TAG_W(TAG_W)) u_cell (
      .clk(clk), .rst(rst),
      .psum_in(psum_chain[g]), .tag_in(tag_chain[g]), .prod(prod),
      .psum_out(psum_chain[g+1]), .tag_out(tag_chain[g+1])
    );
  end

  // Accumulation of kernel-row sums into one output.
  logic [TAG_W-1:0]        row_tag;
  logic                    row_start, row_first, row_last;
  logic [KIDX_W-1:0]       row_kern;
  logic signed [ACC_W-1:0] acc, acc_sum, acc_sat;

  assign row_tag   = tag_chain[KERNEL_COLS];
  assign row_start = row_tag[0];
  assign row_first = row_tag[1];
  assign row_last  = row_tag[2];
  assign out_waddr = row_tag[3 +: OUT_AW];
  assign row_kern  = row_tag[3 + OUT_AW +: KIDX_W];
  assign acc_sum   = (row_first ? (ACC_W'(bias_mem[row_kern]) <<< 8) : acc) +
                     ACC_W'(psum_chain[KERNEL_COLS]);
  assign acc_sat   = acc_sum > SAT_HI ? SAT_HI : (acc_sum < SAT_LO ? SAT_LO : acc_sum);
  assign out_we    = row_start && row_last;
  assign out_wdata = acc_sat[RESULT_W-1:0];

  always_ff @(posedge clk) begin
    if (row_start) begin
      acc <= acc_sum;
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = (state != ST_IDLE) || (rsp_valid && rsp_stall);
    case (state)
      ST_IDLE: begin
        if (req_acc && kind_in == KIND_READ) begin
          state_next = ST_READ;
        end else if (req_acc && kind_in == KIND_START && !size_bad) begin
          state_next = ST_DIV;
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_DIV: begin
        if (div_done) begin
          state_next = (oh_bad || count_bad) ? ST_IDLE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (32'(drain_cnt) == DRAIN_N - 1) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result register and read range flag.
  logic rd_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      out_rows  <= '0;
      out_cols  <= '0;
    end else begin
      if (rsp_acc) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_acc && kind_in == KIND_START && size_bad) begin
            rsp_valid <= 1'b1;
            out_rows  <= '0;
            out_cols  <= '0;
          end
        end
        ST_READ: rsp_valid <= 1'b1;
        ST_DIV: begin
          if (div_done) begin
            if (oh_bad || count_bad) begin
              rsp_valid <= 1'b1;
              out_rows  <= '0;
              out_cols  <= '0;
            end else begin
              out_rows <= quo_r + 1'b1;
              out_cols <= quo_c + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (32'(drain_cnt) == DRAIN_N - 1) begin
            rsp_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rd_ok <= 32'(kernel_sel) < MAX_KERNELS && DIM_W'(row_sel) < out_rows &&
                 DIM_W'(col_sel) < out_cols;
        rem_r <= DIM_W'(32'(ph) - KERNEL_ROWS);
        rem_c <= DIM_W'(32'(pw) - KERNEL_COLS);
        quo_r <= '0;
        quo_c <= '0;
        if (req_acc && kind_in == KIND_START && size_bad) begin
          result_value <= '0;
          status       <= STATUS_BAD_SIZE;
          is_read      <= 1'b0;
        end
      end
      ST_READ: begin
        result_value <= rd_ok ? out_rdata : '0;
        status       <= STATUS_OK;
        is_read      <= 1'b1;
      end
      ST_DIV: begin
        if (rem_r >= DIM_W'(stride_rows)) begin
          rem_r <= rem_r - DIM_W'(stride_rows);
          quo_r <= quo_r + 1'b1;
        end
        if (rem_c >= DIM_W'(stride_cols)) begin
          rem_c <= rem_c - DIM_W'(stride_cols);
          quo_c <= quo_c + 1'b1;
        end
        k         <= '0;
        kg        <= '0;
        base_ch   <= '0;
        c         <= '0;
        oy        <= '0;
        ox        <= '0;
        r         <= '0;
        q         <= '0;
        ybase     <= -$signed(POS_W'(pad_rows));
        xbase     <= -$signed(POS_W'(pad_cols));
        drain_cnt <= '0;
        if (div_done) begin
          result_value <= '0;
          status       <= oh_bad ? STATUS_BAD_SIZE :
                          (count_bad ? STATUS_BAD_COUNT : STATUS_OK);
          is_read      <= 1'b0;
        end
      end
      ST_WALK: begin
        // Innermost to outermost: kernel column, kernel row, channel, output
        // column, output row, kernel.
        if (!q_end) begin
          q <= q + 1'b1;
        end else begin
          q <= '0;
          if (!r_end) begin
            r <= r + 1'b1;
          end else begin
            r <= '0;
            if (!c_end) begin
              c <= c + 1'b1;
            end else begin
              c <= '0;
              if (!ox_end) begin
                ox    <= ox + 1'b1;
                xbase <= xbase + POS_W'(stride_cols);
              end else begin
                ox    <= '0;
                xbase <= -$signed(POS_W'(pad_cols));
                if (!oy_end) begin
                  oy    <= oy + 1'b1;
                  ybase <= ybase + POS_W'(stride_rows);
                end else begin
                  oy    <= '0;
                  ybase <= -$signed(POS_W'(pad_rows));
                  k     <= k + 1'b1;
                  // Kernels of the next group read the next block of channels.
                  if (kg == kpg - 1'b1) begin
                    kg      <= '0;
                    base_ch <= base_ch + cpg;
                  end else begin
                    kg <= kg + 1'b1;
                  end
                end
              end
            end
          end
        end
      end
      ST_DRAIN: drain_cnt <= drain_cnt + 1'b1;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    out_we |-> (state == ST_WALK || state == ST_DRAIN))
    else $error("output store written outside a convolution walk");

  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_IDLE || $past(state) == ST_READ ||
                          $past(state) == ST_DIV || $past(state) == ST_DRAIN))
    else $error("result raised from an unexpected state");

  assert property (@(posedge clk) disable iff (rst)
    (req_acc && kind_in == KIND_START && !size_bad) |=> state == ST_DIV)
    else $error("accepted start did not enter the size divider");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (32'(out_rows) <= MAX_DIM && out_rows != '0 && out_cols != '0))
    else $error("walk running with an illegal output size");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (rsp_valid && is_read))
    else $error("read item gave no read result");

endmodule

`default_nettype wire

// ----- sv/gconv_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module gconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/gconv_cell.sv -----
// One cell of the kernel-row adder chain: adds the broadcast product to the
// partial sum from its left neighbor and hands sum and tag to the right.
// Depends on nothing but its parameters.
`default_nettype none

module gconv_cell #(
  parameter int PSUM_W = 36,
  parameter int TAG_W  = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic signed [PSUM_W-1:0] psum_in,
  input  wire logic        [TAG_W-1:0]  tag_in,
  input  wire logic signed [PSUM_W-1:0] prod,
  output logic signed      [PSUM_W-1:0] psum_out,
  output logic             [TAG_W-1:0]  tag_out
);

  always_ff @(posedge clk) begin
    psum_out <= psum_in + prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for grouped_conv2d_engine_unit: random and directed
// loads, starts and output reads checked against a built-in convolution predictor.
// Depends on gconv_pkg and the engine RTL.
`default_nettype none

module testbench;
  import gconv_pkg::*;

  localparam int KR = 3;
  localparam int KC = 3;
  localparam int GROUPS = 1;
  localparam int DIM = 64;
  localparam int CHANS = 16;
  localparam int KERNS = 16;
  localparam int PLANE = DIM * DIM;
  localparam int WIN = KR * KC;
  localparam int TARGET_ITEMS = 1700;
  localparam int DRAIN_CYCLES = 20;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct {
    logic [2:0] kind;
    logic [3:0] ks;
    logic [3:0] cs;
    logic [5:0] rs;
    logic [5:0] cl;
    logic signed [15:0] val;
  } conv_req_t;

  typedef struct {
    logic signed [39:0] result;
    status_t stat;
    logic rd;
  } conv_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [2:0] kind = '0;
  logic [3:0] kernel_sel = '0;
  logic [3:0] chan_sel = '0;
  logic [5:0] row_sel = '0;
  logic [5:0] col_sel = '0;
  logic signed [15:0] value = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic signed [39:0] result_value;
  logic [1:0] status;
  logic is_read;

  grouped_conv2d_engine_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .kind(kind), .kernel_sel(kernel_sel),
    .chan_sel(chan_sel), .row_sel(row_sel), .col_sel(col_sel), .value(value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .result_value(result_value),
    .status(status), .is_read(is_read)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state, updated as items are accepted.
  logic [6:0] conv_cfg [8];
  logic signed [15:0] pix_mem [PLANE*CHANS];
  logic signed [15:0] wgt_mem [KERNS*CHANS*WIN];
  logic signed [15:0] bias_mem [KERNS];
  logic signed [39:0] out_mem [PLANE*KERNS];
  int out_rows, out_cols;

  // Generator bookkeeping: which entries the queued items have written.
  bit pix_set [PLANE*CHANS];
  bit wgt_set [KERNS*CHANS*WIN];
  bit out_set [PLANE*KERNS];
  int plan_rows, plan_cols, plan_kernels;

  conv_req_t pending_items[$];
  conv_rsp_t expected_results[$];
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int queued_count = 0;
  longint cycles = 0;
  bit req_taken = 1'b0;

  function automatic status_t size_status();
    int ih, iw, ic, kc, sr, sc, ph, pw;
    ih = conv_cfg[REG_IN_HEIGHT];
    iw = conv_cfg[REG_IN_WIDTH];
    ic = conv_cfg[REG_IN_CHANNELS];
    kc = conv_cfg[REG_KERNEL_COUNT];
    sr = conv_cfg[REG_STRIDE_ROWS];
    sc = conv_cfg[REG_STRIDE_COLS];
    ph = ih + 2 * conv_cfg[REG_PAD_ROWS];
    pw = iw + 2 * conv_cfg[REG_PAD_COLS];
    if (sr == 0 || sc == 0 || ih == 0 || iw == 0 || ih > DIM || iw > DIM) return STATUS_BAD_SIZE;
    if (ph < KR || pw < KC) return STATUS_BAD_SIZE;
    if ((ph - KR) / sr + 1 > DIM || (pw - KC) / sc + 1 > DIM) return STATUS_BAD_SIZE;
    if (ic == 0 || ic > CHANS || kc == 0 || kc > KERNS) return STATUS_BAD_COUNT;
    if (ic % GROUPS != 0 || kc % GROUPS != 0) return STATUS_BAD_COUNT;
    return STATUS_OK;
  endfunction

  function automatic int map_rows();
    return (conv_cfg[REG_IN_HEIGHT] + 2 * conv_cfg[REG_PAD_ROWS] - KR)
           / conv_cfg[REG_STRIDE_ROWS] + 1;
  endfunction

  function automatic int map_cols();
    return (conv_cfg[REG_IN_WIDTH] + 2 * conv_cfg[REG_PAD_COLS] - KC)
           / conv_cfg[REG_STRIDE_COLS] + 1;
  endfunction

  task automatic convolve_all();
    int ih, iw, sr, sc, pr, pc, cpg, kpg, base, y, x;
    longint acc;
    ih = conv_cfg[REG_IN_HEIGHT];
    iw = conv_cfg[REG_IN_WIDTH];
    sr = conv_cfg[REG_STRIDE_ROWS];
    sc = conv_cfg[REG_STRIDE_COLS];
    pr = conv_cfg[REG_PAD_ROWS];
    pc = conv_cfg[REG_PAD_COLS];
    cpg = conv_cfg[REG_IN_CHANNELS] / GROUPS;
    kpg = conv_cfg[REG_KERNEL_COUNT] / GROUPS;
    out_rows = map_rows();
    out_cols = map_cols();
    for (int k = 0; k < conv_cfg[REG_KERNEL_COUNT]; k++) begin
      base = (k / kpg) * cpg;
      for (int oy = 0; oy < out_rows; oy++)
        for (int ox = 0; ox < out_cols; ox++) begin
          acc = longint'(bias_mem[k]) * 256;
          for (int c = 0; c < cpg; c++)
            for (int r = 0; r < KR; r++) begin
              y = oy * sr + r - pr;
              if (y >= 0 && y < ih)
                for (int q = 0; q < KC; q++) begin
                  x = ox * sc + q - pc;
                  if (x >= 0 && x < iw)
                    acc += longint'(pix_mem[(base + c) * PLANE + y * DIM + x]) *
                           longint'(wgt_mem[(k * CHANS + c) * WIN + r * KC + q]);
                end
            end
          if (acc > 64'sd549755813887) acc = 64'sd549755813887;
          if (acc < -64'sd549755813888) acc = -64'sd549755813888;
          out_mem[k * PLANE + oy * DIM + ox] = acc[39:0];
        end
    end
  endtask

  task automatic apply_request(input conv_req_t it);
    conv_rsp_t exp_rsp;
    exp_rsp.result = '0;
    exp_rsp.stat = STATUS_OK;
    exp_rsp.rd = 1'b0;
    case (it.kind)
      KIND_WEIGHT: if (it.rs < KR && it.cl < KC)
        wgt_mem[(it.ks * CHANS + it.cs) * WIN + it.rs * KC + it.cl] = it.val;
      KIND_BIAS: bias_mem[it.ks] = it.val;
      KIND_PIXEL: pix_mem[it.cs * PLANE + it.rs * DIM + it.cl] = it.val;
      KIND_START: begin
        exp_rsp.stat = size_status();
        if (exp_rsp.stat == STATUS_OK) convolve_all();
        else begin
          out_rows = 0;
          out_cols = 0;
        end
        expected_results.push_back(exp_rsp);
      end
      KIND_READ: begin
        if (it.rs < out_rows && it.cl < out_cols)
          exp_rsp.result = out_mem[it.ks * PLANE + it.rs * DIM + it.cl];
        exp_rsp.rd = 1'b1;
        expected_results.push_back(exp_rsp);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    fail_count++;
  endtask

  // Monitor and predictor: outputs are sampled at the rising edge.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end else if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) report_mismatch("result with nothing expected");
        else begin
          if (result_value !== expected_results[0].result)
            report_mismatch($sformatf("result_value %0d, expected %0d", result_value,
                                      expected_results[0].result));
          if (status !== expected_results[0].stat)
            report_mismatch($sformatf("status %0d, expected %0d", status,
                                      expected_results[0].stat));
          if (is_read !== expected_results[0].rd)
            report_mismatch($sformatf("is_read %0b, expected %0b", is_read,
                                      expected_results[0].rd));
          void'(expected_results.pop_front());
        end
      end
      req_taken = req_valid && !req_stall;
      if (req_taken)
        apply_request('{kind, kernel_sel, chan_sel, row_sel, col_sel, value});
    end
  end

  // Driver: inputs change at the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (!req_valid || req_taken) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          req_valid <= 1'b1;
          kind <= pending_items[0].kind;
          kernel_sel <= pending_items[0].ks;
          chan_sel <= pending_items[0].cs;
          row_sel <= pending_items[0].rs;
          col_sel <= pending_items[0].cl;
          value <= pending_items[0].val;
          void'(pending_items.pop_front());
        end else
          req_valid <= 1'b0;
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_item(input logic [2:0] k, input int ks, input int cs, input int rs,
                           input int cl, input logic signed [15:0] v);
    conv_req_t it;
    it = '{k, 4'(ks), 4'(cs), 6'(rs), 6'(cl), v};
    case (k)
      KIND_WEIGHT: if (rs < KR && cl < KC) wgt_set[(ks * CHANS + cs) * WIN + rs * KC + cl] = 1;
      KIND_PIXEL: pix_set[cs * PLANE + rs * DIM + cl] = 1;
      default: ;
    endcase
    pending_items.push_back(it);
    queued_count++;
  endtask

  // Reads inside the planned output size never touch an output entry that no start has written.
  task automatic push_read(input int ks, input int rs, input int cl);
    if (rs < plan_rows && cl < plan_cols && !out_set[ks * PLANE + rs * DIM + cl])
      ks = $urandom_range(0, plan_kernels - 1);
    push_item(KIND_READ, ks, cs_noise(), rs, cl, rand_value());
  endtask

  function automatic int cs_noise();
    return $urandom_range(0, 15);
  endfunction

  task automatic push_start();
    push_item(KIND_START, $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
    if (size_status() == STATUS_OK) begin
      plan_rows = map_rows();
      plan_cols = map_cols();
      plan_kernels = conv_cfg[REG_KERNEL_COUNT];
      for (int k = 0; k < plan_kernels; k++)
        for (int oy = 0; oy < plan_rows; oy++)
          for (int ox = 0; ox < plan_cols; ox++) out_set[k * PLANE + oy * DIM + ox] = 1;
    end else begin
      plan_rows = 0;
      plan_cols = 0;
    end
  endtask

  task automatic push_random_item();
    int pick, ih, hi;
    pick = $urandom_range(0, 99);
    ih = conv_cfg[REG_IN_HEIGHT];
    hi = (ih >= 1 && ih <= DIM) ? ih - 1 : 63;
    if (pick < 30)
      push_item(KIND_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 15),
                ($urandom_range(0, 9) < 8) ? $urandom_range(0, KR - 1) : $urandom_range(0, 63),
                ($urandom_range(0, 9) < 8) ? $urandom_range(0, KC - 1) : $urandom_range(0, 63),
                rand_value());
    else if (pick < 42)
      push_item(KIND_BIAS, $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
    else if (pick < 75)
      push_item(KIND_PIXEL, $urandom_range(0, 15), $urandom_range(0, 15),
                ($urandom_range(0, 9) < 8) ? $urandom_range(0, hi) : $urandom_range(0, 63),
                $urandom_range(0, 63), rand_value());
    else if (pick < 94)
      push_read($urandom_range(0, 15),
                ($urandom_range(0, 3) != 0 && plan_rows > 0) ? $urandom_range(0, plan_rows - 1)
                                                             : $urandom_range(0, 63),
                ($urandom_range(0, 3) != 0 && plan_cols > 0) ? $urandom_range(0, plan_cols - 1)
                                                             : $urandom_range(0, 63));
    else
      push_item(3'($urandom_range(5, 7)), $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
  endtask

  // Loads every pixel and weight the next start will use that is still unwritten.
  task automatic fill_operands();
    int ic;
    if (size_status() == STATUS_OK) begin
      ic = conv_cfg[REG_IN_CHANNELS];
      for (int ch = 0; ch < ic; ch++)
        for (int y = 0; y < conv_cfg[REG_IN_HEIGHT]; y++)
          for (int x = 0; x < conv_cfg[REG_IN_WIDTH]; x++)
            if (!pix_set[ch * PLANE + y * DIM + x]) push_item(KIND_PIXEL, 0, ch, y, x, rand_value());
      for (int k = 0; k < conv_cfg[REG_KERNEL_COUNT]; k++)
        for (int c = 0; c < ic / GROUPS; c++)
          for (int t = 0; t < WIN; t++)
            if (!wgt_set[(k * CHANS + c) * WIN + t])
              push_item(KIND_WEIGHT, k, c, t / KC, t % KC, rand_value());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input int vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= 7'(vals[i]);
      conv_cfg[i] = 7'(vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin sender_idle_pct = 0; stall_pct = 0; end
      1: begin sender_idle_pct = 58; stall_pct = 0; end
      2: begin sender_idle_pct = 0; stall_pct = 58; end
      default: begin sender_idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  task automatic run_phase(input int phase, input int vals [8], input int n_random);
    wait_drained();
    write_config(vals);
    set_idling(phase);
    repeat (n_random / 2) push_random_item();
    fill_operands();
    push_start();
    repeat (n_random / 2) push_random_item();
    if ($urandom_range(0, 2) == 0) begin
      push_start();
      repeat (8) push_random_item();
    end
  endtask

  int directed_cfgs [14][8] = '{
    '{8, 8, 1, 1, 1, 1, 0, 0},
    '{64, 64, 1, 1, 8, 8, 4, 4},
    '{3, 3, 16, 1, 1, 1, 0, 0},
    '{3, 3, 1, 16, 1, 1, 0, 0},
    '{1, 1, 1, 1, 1, 1, 1, 1},
    '{8, 8, 1, 1, 15, 15, 7, 7},
    '{1, 1, 1, 1, 1, 1, 0, 0},
    '{0, 8, 1, 1, 1, 1, 0, 0},
    '{127, 8, 1, 1, 1, 1, 0, 0},
    '{8, 8, 1, 1, 0, 1, 0, 0},
    '{64, 64, 1, 1, 1, 1, 4, 4},
    '{8, 8, 0, 1, 1, 1, 0, 0},
    '{8, 8, 31, 1, 1, 1, 0, 0},
    '{8, 8, 1, 17, 1, 1, 0, 0}
  };

  initial begin
    int vals [8];
    int phase;
    for (int i = 0; i < PLANE * CHANS; i++) pix_mem[i] = '0;
    for (int i = 0; i < KERNS * CHANS * WIN; i++) wgt_mem[i] = '0;
    for (int i = 0; i < KERNS; i++) bias_mem[i] = '0;
    for (int i = 0; i < PLANE * KERNS; i++) out_mem[i] = '0;
    out_rows = 0;
    out_cols = 0;
    plan_rows = 0;
    plan_cols = 0;
    plan_kernels = 1;
    vals = '{8, 8, 1, 1, 1, 1, 0, 0};
    for (int i = 0; i < 8; i++) conv_cfg[i] = 7'(vals[i]);
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed opening: extreme values, ignored loads, unknown kinds, reads before any start.
    push_read(0, 0, 0);
    push_item(KIND_WEIGHT, 0, 0, 0, 0, 16'sh7FFF);
    push_item(KIND_WEIGHT, 0, 0, 2, 2, 16'sh8000);
    push_item(KIND_WEIGHT, 15, 15, 3, 0, 16'sh1234);
    push_item(KIND_WEIGHT, 15, 15, 0, 63, 16'sh4321);
    push_item(KIND_BIAS, 0, 0, 0, 0, 16'sh7FFF);
    push_item(KIND_BIAS, 15, 0, 0, 0, 16'sh8000);
    push_item(KIND_PIXEL, 0, 0, 0, 0, 16'sh8000);
    push_item(KIND_PIXEL, 15, 15, 63, 63, 16'sh7FFF);
    push_item(3'd5, 15, 15, 63, 63, 16'sh7FFF);
    push_item(3'd6, 0, 0, 0, 0, 16'sh0000);
    push_item(3'd7, 10, 5, 42, 21, 16'sh5555);
    fill_operands();
    push_start();
    push_read(0, 0, 0);
    push_read(0, 5, 5);
    push_read(0, 6, 0);
    push_read(0, 0, 6);
    push_read(15, 63, 63);

    for (phase = 1; phase < 14; phase++)
      run_phase(phase, directed_cfgs[phase], 10);
    while (queued_count < TARGET_ITEMS + 1000) begin
      if ($urandom_range(0, 9) == 0)
        vals = '{$urandom_range(0, 127), $urandom_range(1, 8), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(1, 3),
                 $urandom_range(0, 7), $urandom_range(0, 2)};
      else
        vals = '{$urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 3),
                 $urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3),
                 $urandom_range(0, 2), $urandom_range(0, 2)};
      run_phase(phase, vals, 60);
      phase++;
    end
    wait_drained();
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
